// ===== src/assert_macros.svh =====
// Assertion helpers shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/vpem_pkg.sv =====
package vpem_pkg;

   // Sizes of the color RAM and of the request and response fields.
   localparam int COLOR_RAM_WORDS = 64;
   localparam int WORD_W          = 16;
   localparam int INDEX_W         = 8;
   localparam int ENTRY_W         = 6;
   localparam int CODE_W          = 12;
   localparam int REQ_TDATA_W     = 24;
   localparam int RSP_TDATA_W     = 16;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 6;

   // Request kinds carried on tuser.
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // Color masks and highlight constants for the twelve-bit console mode.
   localparam logic [CODE_W-1:0] MASK_M4_OFF = 12'h222;
   localparam logic [CODE_W-1:0] MASK_M4_ON  = 12'hEEE;
   localparam logic [CODE_W-1:0] HL_BASE     = 12'h888;
   localparam logic [CODE_W-1:0] HL_BIAS     = 12'h111;

   localparam logic [1:0] MODE_BITS_RESET = 2'b11;

   typedef enum logic [1:0] {
      SRC_BLANK  = 2'd0,
      SRC_TWELVE = 2'd1,
      SRC_SIX    = 2'd2
   } src_type;

   typedef enum logic [1:0] {
      PM_CONSOLE12 = 2'd0,
      PM_CONSOLE6  = 2'd1,
      PM_HANDHELD  = 2'd2,
      PM_LEGACY    = 2'd3
   } pmode_type;

   typedef enum logic [1:0] {
      GRP_NORMAL    = 2'd0,
      GRP_SHADOW    = 2'd1,
      GRP_HIGHLIGHT = 2'd2,
      GRP_COPY      = 2'd3
   } group_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PALETTE_MODE = 2'd0,
      CSR_MODE_BITS    = 2'd1,
      CSR_SH_ON        = 2'd2,
      CSR_BACKGROUND   = 2'd3
   } csr_index_type;

   // Configuration seen by the entry mapping logic.
   typedef struct packed {
      pmode_type          palette_mode;
      logic [1:0]         mode_bits;
      logic               sh_on;
      logic [ENTRY_W-1:0] background;
   } cfg_type;

   // One mapped palette entry.
   typedef struct packed {
      logic               defined;
      logic [CODE_W-1:0]  code;
      src_type            source;
   } result_type;

   // Fixed sixteen-color table of the six-bit console without M4.
   function automatic logic [5:0] fixed16(input logic [3:0] idx);
      logic [5:0] val;
      case (idx)
         4'd0:    val = 6'h00;
         4'd1:    val = 6'h00;
         4'd2:    val = 6'h08;
         4'd3:    val = 6'h0C;
         4'd4:    val = 6'h10;
         4'd5:    val = 6'h30;
         4'd6:    val = 6'h01;
         4'd7:    val = 6'h3C;
         4'd8:    val = 6'h02;
         4'd9:    val = 6'h03;
         4'd10:   val = 6'h05;
         4'd11:   val = 6'h0F;
         4'd12:   val = 6'h04;
         4'd13:   val = 6'h33;
         4'd14:   val = 6'h15;
         default: val = 6'h3F;
      endcase
      return val;
   endfunction

endpackage

// ===== src/vpem_ram.sv =====
module vpem_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/vpem_entry_calc.sv =====
module vpem_entry_calc (
   input  vpem_pkg::cfg_type                 cfg,
   input  logic [vpem_pkg::ENTRY_W-1:0]      entry,
   input  vpem_pkg::group_type               group,
   input  logic [vpem_pkg::WORD_W-1:0]       word,
   output vpem_pkg::result_type              result
);
   import vpem_pkg::*;

   logic              m4;
   logic              m5;
   logic [CODE_W-1:0] masked;
   logic [CODE_W-1:0] half;
   logic [5:0]        six_code;
   logic [7:0]        byte_sel;
   logic              low_half;

   assign m4       = cfg.mode_bits[0];
   assign m5       = cfg.mode_bits[1];
   assign masked   = word[CODE_W-1:0] & (m4 ? MASK_M4_ON : MASK_M4_OFF);
   assign half     = masked >> 1;
   assign six_code = {word[10:9], word[6:5], word[2:1]};
   assign byte_sel = entry[0] ? word[15:8] : word[7:0];
   assign low_half = (entry < ENTRY_W'(32));

   // Map the entry according to palette mode, M5/M4 and its group.
   always_comb begin
      result = '{defined: 1'b0, code: '0, source: SRC_BLANK};
      case (cfg.palette_mode)
         PM_CONSOLE12: begin
            if (group == GRP_COPY && !(m5 && cfg.sh_on)) begin
               result.defined = 1'b0;
            end else if (!m5 && !m4) begin
               // Mode with no color RAM: normal entries read as blank.
               result.defined = (group == GRP_NORMAL);
            end else if (!m5) begin
               if (group == GRP_NORMAL && low_half) begin
                  result = '{defined: 1'b1, code: CODE_W'(six_code), source: SRC_SIX};
               end
            end else if (group == GRP_NORMAL || group == GRP_COPY) begin
               result = '{defined: 1'b1, code: masked, source: SRC_TWELVE};
            end else if (cfg.sh_on && group == GRP_SHADOW) begin
               result = '{defined: 1'b1, code: half, source: SRC_TWELVE};
            end else if (cfg.sh_on) begin
               result = '{defined: 1'b1, code: (HL_BASE | half) - HL_BIAS,
                          source: SRC_TWELVE};
            end
         end
         PM_CONSOLE6: begin
            if (group == GRP_NORMAL && low_half) begin
               if (m4) begin
                  result = '{defined: 1'b1, code: CODE_W'(byte_sel[5:0]), source: SRC_SIX};
               end else begin
                  result = '{defined: 1'b1, code: CODE_W'(fixed16(entry[3:0])),
                             source: SRC_SIX};
               end
            end
         end
         PM_HANDHELD: begin
            if (group == GRP_NORMAL && low_half) begin
               result = '{defined: 1'b1, code: word[CODE_W-1:0], source: SRC_TWELVE};
            end
         end
         default: begin
            if (group == GRP_NORMAL && low_half) begin
               result = '{defined: 1'b1, code: CODE_W'(entry[3:0]), source: SRC_SIX};
            end
         end
      endcase
   end

endmodule

// ===== src/video_palette_entry_mapper_core.sv =====
// Channel | Direction | Handshake           | Payload
// req     | in        | req_tvalid/tready   | tuser kind, tdata index and write word
// rsp     | out       | rsp_tvalid/tready   | tdata source, color code, defined flag
// csr     | in        | csr_we              | csr_index, csr_wdata
//
// One request per cycle is accepted while the response is not stalled; a lookup response
// passes through the color RAM read port register, then the entry mapping into the response register.
// Writes give no response and update the color RAM at the accepting edge.
// Reset is synchronous; the color RAM valid bits clear at once, so unwritten
// words read as zero and no clearing pass is needed.
// A stalled response holds; new requests are taken while the response register drains.
module video_palette_entry_mapper_core #(
   parameter int COLOR_RAM_WORDS = vpem_pkg::COLOR_RAM_WORDS
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request: tuser = kind.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tuser,
   // tdata from bit 0: entry_index[7:0], write_word[23:8].
   input  logic [vpem_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tdata from bit 0: table_source[1:0], color_code[13:2], entry_defined[14], zero[15].
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [vpem_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // Configuration writes.
   input  logic                               csr_we,
   input  logic [vpem_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [vpem_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import vpem_pkg::*;

   localparam int ADDR_W = $clog2(COLOR_RAM_WORDS);

   // Configuration registers.
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Request decode.
   logic [INDEX_W-1:0] req_index;
   logic [WORD_W-1:0]  req_word;
   logic [ENTRY_W-1:0] req_entry;
   logic               req_accept;
   logic               ram_we;
   logic               ram_re;
   logic               byte_mode;
   logic [ADDR_W-1:0]  rd_addr;

   // Color RAM written flags.
   logic [COLOR_RAM_WORDS-1:0] known_ff;
   logic [COLOR_RAM_WORDS-1:0] known_in;

   // Stage 1: RAM read in flight.
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [ENTRY_W-1:0] s1_entry_ff;
   group_type          s1_group_ff;
   logic               s1_known_ff;
   logic [WORD_W-1:0]  ram_rd_data;
   logic [WORD_W-1:0]  s1_word;

   // Response register.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   result_type         rsp_data_ff;
   result_type         calc_result;
   logic               rsp_load;
   logic               s1_advance;

   // Configuration write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PALETTE_MODE: cfg_in.palette_mode = pmode_type'(csr_wdata[1:0]);
            CSR_MODE_BITS:    cfg_in.mode_bits    = csr_wdata[1:0];
            CSR_SH_ON:        cfg_in.sh_on        = csr_wdata[0];
            default:          cfg_in.background   = csr_wdata[ENTRY_W-1:0];
         endcase
      end
   end

   // Handshake: the response register frees stage 1, which frees the input.
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && rsp_load;
   assign req_tready = !s1_valid_ff || rsp_load;
   assign req_accept = req_tvalid && req_tready;

   // Entry zero of a group reads the background entry; six-bit byte mode reads word e/2.
   assign req_index = req_tdata[INDEX_W-1:0];
   assign req_word  = req_tdata[INDEX_W +: WORD_W];
   assign req_entry = (req_index[ENTRY_W-1:0] == '0) ? cfg_ff.background
                                                    : req_index[ENTRY_W-1:0];
   assign byte_mode = (cfg_ff.palette_mode == PM_CONSOLE6) && cfg_ff.mode_bits[0];
   assign rd_addr   = byte_mode ? ADDR_W'(req_entry >> 1) : ADDR_W'(req_entry);
   assign ram_re    = req_accept && (req_tuser == KIND_LOOKUP);
   assign ram_we    = req_accept && (req_tuser == KIND_WRITE)
                      && (32'(req_index) < COLOR_RAM_WORDS);

   // Written flags, set with each in-range write.
   always_comb begin
      known_in = known_ff;
      if (ram_we) begin
         known_in[req_index[ADDR_W-1:0]] = 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = (req_tuser == KIND_LOOKUP);
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   vpem_ram #(
      .WIDTH (WORD_W),
      .DEPTH (COLOR_RAM_WORDS)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_index[ADDR_W-1:0]),
      .wr_data (req_word),
      .rd_en   (ram_re),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // Words never written read as zero.
   assign s1_word = s1_known_ff ? ram_rd_data : '0;

   vpem_entry_calc u_entry_calc (
      .cfg    (cfg_ff),
      .entry  (s1_entry_ff),
      .group  (s1_group_ff),
      .word   (s1_word),
      .result (calc_result)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{palette_mode: PM_CONSOLE12, mode_bits: MODE_BITS_RESET,
                           sh_on: 1'b0, background: '0};
         known_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         known_ff     <= known_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ram_re) begin
         s1_entry_ff <= req_entry;
         s1_group_ff <= group_type'(req_index[INDEX_W-1:ENTRY_W]);
         s1_known_ff <= known_ff[rd_addr];
      end
      if (s1_advance) begin
         rsp_data_ff <= calc_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.defined, rsp_data_ff.code, rsp_data_ff.source};

endmodule

// ===== src/vpem_checker.sv =====
`include "assert_macros.svh"

module vpem_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tuser,
   input logic [vpem_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [vpem_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                               csr_we,
   input logic [vpem_pkg::CSR_INDEX_W-1:0]   csr_index,
   input logic [vpem_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import vpem_pkg::*;

   // A stalled response stays offered.
   `ASSERT_CLK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "response dropped while stalled")

   // Reset empties the response register.
   `ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_tvalid, "response valid after reset")

   // Outside the twelve-bit and six-bit tables the code is zero, whether defined or not.
   `ASSERT_CLK(a_src_code, rsp_tvalid && rsp_tdata[1:0] != SRC_SIX && rsp_tdata[1:0] != SRC_TWELVE |-> rsp_tdata[15:2] == 14'h1000 || rsp_tdata[15:2] == 14'h0000, "bad table source or blank code")

   // An undefined entry reads as blank with code zero.
   `ASSERT_CLK(a_undef_blank, rsp_tvalid && !rsp_tdata[14] |-> rsp_tdata[13:0] == 14'h0000, "undefined entry not blank")

endmodule

bind video_palette_entry_mapper_core vpem_checker u_vpem_checker (.*);
